// ===== rtl/mrpt_pkg.sv =====
// Shared types, constants and helpers for the 32-bit Miller-Rabin prime test.
package mrpt_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned BitCntW = 5;   // counts 0..31 bit steps
    localparam int unsigned BaseCnt = 3;

    // Request into the shared modular multiplier
    typedef struct packed {
        logic             start;
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
    } mm_req_t;

    // Status out of the shared modular multiplier
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WordW-1:0] product;
    } mm_rsp_t;

    // Witness bases 2, 3, 5 in test order
    function automatic logic [WordW-1:0] base_of(input logic [1:0] idx);
        logic [WordW-1:0] b;
        case (idx)
            2'd0:    b = WordW'(2);
            2'd1:    b = WordW'(3);
            default: b = WordW'(5);
        endcase
        return b;
    endfunction

    // Strong pseudoprimes to bases 2, 3 and 5 below 2^32
    function automatic logic is_spsp(input logic [WordW-1:0] n);
        return (n == 32'd25326001)   || (n == 32'd161304001)  ||
               (n == 32'd960946321)  || (n == 32'd1157839381) ||
               (n == 32'd3215031751) || (n == 32'd3697278427);
    endfunction

endpackage

// ===== rtl/mrpt_mulmod.sv =====
// Bit-serial interleaved modular multiplier: product = a * b mod n, one bit of a per cycle.
module mrpt_mulmod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mrpt_pkg::mm_req_t            req,
    input  logic [mrpt_pkg::WordW-1:0]   modulus,
    output mrpt_pkg::mm_rsp_t            rsp
);

    localparam int unsigned W = mrpt_pkg::WordW;

    logic                             busy_reg;
    logic                             done_reg;
    logic [mrpt_pkg::BitCntW-1:0]     cnt_reg;
    logic [W-1:0]                     a_reg;
    logic [W-1:0]                     b_reg;
    logic [W-1:0]                     n_reg;
    logic [W-1:0]                     acc_reg;

    logic [W+1:0] sum;
    logic [W+1:0] sub1;
    logic [W+1:0] sub2;
    logic [W-1:0] acc_step;

    // acc < n and b < n, so 2*acc + b < 3n; pick the one reduction that lands in [0, n)
    always_comb begin
        sum  = {1'b0, acc_reg, 1'b0} + (a_reg[W-1] ? {2'b00, b_reg} : '0);
        sub1 = sum - {2'b00, n_reg};
        sub2 = sum - {1'b0, n_reg, 1'b0};
        if (!sub2[W+1]) begin
            acc_step = sub2[W-1:0];
        end else if (!sub1[W+1]) begin
            acc_step = sub1[W-1:0];
        end else begin
            acc_step = sum[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= mrpt_pkg::BitCntW'(W - 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            acc_reg <= acc_step;
            a_reg   <= {a_reg[W-2:0], 1'b0};
        end else if (req.start) begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
            n_reg   <= modulus;
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== rtl/miller_rabin_prime_test_u32.sv =====
// Top level of the deterministic Miller-Rabin primality test for 32-bit numbers.
//
// Usage:
//   Input channel s_*: one item is one 32-bit candidate on s_tdata, taken when
//   s_tvalid and s_tready are both high. s_tready is high only while the block
//   is idle; one item is processed at a time.
//   Output channel m_*: one item per candidate, m_tdata[0] = is_prime.
//   The result sits in an output register until m_tready takes it; a stalled
//   receiver only holds the sequencer in its final state, no result is lost.
// Sequence:
//   Settled cases (below 2, even, 2/3/5, six pseudoprimes): go from ST_IDLE to ST_FINISH and the output register.
//   Otherwise: ST_SPLIT splits n-1 into d * 2^s, then per base
//   (2, 3, 5; stops at the first failing base) one square per bit of d, one
//   multiply per set bit of d, and up to s-1 further squarings. Each modular
//   multiply holds the shared bit-serial unit from its start through one step
//   per bit of a (a done in ST_EXPMUL or ST_SQR may start the next one in the
//   same cycle); each bit of d also passes ST_EXPCHK to pick the step. The worst
//   case is d of 31 set bits. The throughput is set mostly by that multiply unit.
// Reset: aresetn (synchronous, active low) returns to idle and drops m_tvalid.
module miller_rabin_prime_test_u32 (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] candidate
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [0] is_prime, [7:1] zero
);

    localparam int unsigned W = mrpt_pkg::WordW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SPLIT  = 3'd1;  // strip factors of two from n-1
    localparam logic [2:0] ST_EXPCHK = 3'd2;  // pick next exponent step
    localparam logic [2:0] ST_EXPMUL = 3'd3;  // acc = acc * sq
    localparam logic [2:0] ST_EXPSQ  = 3'd4;  // sq = sq * sq
    localparam logic [2:0] ST_TEST   = 3'd5;  // check x = 1 or n-1
    localparam logic [2:0] ST_SQR    = 3'd6;  // repeated squaring of x
    localparam logic [2:0] ST_FINISH = 3'd7;  // hand result to output register

    logic [2:0]                   state_reg,  state_next;
    logic [W-1:0]                 n_reg,      n_next;
    logic [W-1:0]                 d_reg,      d_next;
    logic [mrpt_pkg::BitCntW-1:0] s_reg,      s_next;
    logic [mrpt_pkg::BitCntW-1:0] r_reg,      r_next;
    logic [1:0]                   base_reg,   base_next;
    logic [W-1:0]                 e_reg,      e_next;
    logic [W-1:0]                 acc_reg,    acc_next;
    logic [W-1:0]                 sq_reg,     sq_next;
    logic                         res_reg,    res_next;
    logic                         mvalid_reg, mvalid_next;
    logic                         prime_reg,  prime_next;

    mrpt_pkg::mm_req_t mm_req;
    mrpt_pkg::mm_rsp_t mm_rsp;

    logic [W-1:0] nm1;
    logic         in_fire;
    logic         out_load;
    logic         trivial;
    logic         trivial_res;

    assign nm1      = n_reg - 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FINISH) && (!mvalid_reg || m_tready);

    // Cases settled without running the base tests
    always_comb begin
        trivial     = 1'b1;
        trivial_res = 1'b0;
        if (s_tdata < W'(2)) begin
            trivial_res = 1'b0;
        end else if (s_tdata == W'(2) || s_tdata == W'(3) || s_tdata == W'(5)) begin
            trivial_res = 1'b1;
        end else if (!s_tdata[0]) begin
            trivial_res = 1'b0;
        end else if (mrpt_pkg::is_spsp(s_tdata)) begin
            trivial_res = 1'b0;
        end else begin
            trivial = 1'b0;
        end
    end

    mrpt_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .modulus (n_reg),
        .rsp     (mm_rsp)
    );

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        s_next      = s_reg;
        r_next      = r_reg;
        base_next   = base_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        res_next    = res_reg;
        mvalid_next = mvalid_reg && !m_tready;
        prime_next  = prime_reg;
        mm_req      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    n_next = s_tdata;
                    d_next = s_tdata - 1'b1;
                    s_next = '0;
                    if (trivial) begin
                        res_next   = trivial_res;
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                if (!d_reg[0]) begin
                    d_next = {1'b0, d_reg[W-1:1]};
                    s_next = s_reg + 1'b1;
                end else begin
                    base_next  = '0;
                    acc_next   = W'(1);
                    sq_next    = mrpt_pkg::base_of(2'd0);
                    e_next     = d_reg;
                    state_next = ST_EXPCHK;
                end
            end
            ST_EXPCHK: begin
                if (e_reg == '0) begin
                    state_next = ST_TEST;
                end else if (e_reg[0]) begin
                    mm_req.start = 1'b1;
                    mm_req.a     = acc_reg;
                    mm_req.b     = sq_reg;
                    state_next   = ST_EXPMUL;
                end else begin
                    mm_req.start = 1'b1;
                    mm_req.a     = sq_reg;
                    mm_req.b     = sq_reg;
                    state_next   = ST_EXPSQ;
                end
            end
            ST_EXPMUL: begin
                if (mm_rsp.done) begin
                    acc_next     = mm_rsp.product;
                    mm_req.start = 1'b1;
                    mm_req.a     = sq_reg;
                    mm_req.b     = sq_reg;
                    state_next   = ST_EXPSQ;
                end
            end
            ST_EXPSQ: begin
                if (mm_rsp.done) begin
                    sq_next    = mm_rsp.product;
                    e_next     = {1'b0, e_reg[W-1:1]};
                    state_next = ST_EXPCHK;
                end
            end
            ST_TEST: begin
                r_next = s_reg - 1'b1;
                if (acc_reg == W'(1) || acc_reg == nm1) begin
                    // base passes
                    if (base_reg == 2'(mrpt_pkg::BaseCnt - 1)) begin
                        res_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        base_next  = base_reg + 1'b1;
                        acc_next   = W'(1);
                        sq_next    = mrpt_pkg::base_of(base_reg + 1'b1);
                        e_next     = d_reg;
                        state_next = ST_EXPCHK;
                    end
                end else if (s_reg == 5'(1)) begin
                    res_next   = 1'b0;
                    state_next = ST_FINISH;
                end else begin
                    mm_req.start = 1'b1;
                    mm_req.a     = acc_reg;
                    mm_req.b     = acc_reg;
                    state_next   = ST_SQR;
                end
            end
            ST_SQR: begin
                if (mm_rsp.done) begin
                    acc_next = mm_rsp.product;
                    r_next   = r_reg - 1'b1;
                    if (mm_rsp.product == nm1) begin
                        if (base_reg == 2'(mrpt_pkg::BaseCnt - 1)) begin
                            res_next   = 1'b1;
                            state_next = ST_FINISH;
                        end else begin
                            base_next  = base_reg + 1'b1;
                            acc_next   = W'(1);
                            sq_next    = mrpt_pkg::base_of(base_reg + 1'b1);
                            e_next     = d_reg;
                            state_next = ST_EXPCHK;
                        end
                    end else if (mm_rsp.product == W'(1) || r_reg == 5'(1)) begin
                        // hit 1 early, or squarings used up without n-1
                        res_next   = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        mm_req.start = 1'b1;
                        mm_req.a     = mm_rsp.product;
                        mm_req.b     = mm_rsp.product;
                    end
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    mvalid_next = 1'b1;
                    prime_next  = res_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        r_reg     <= r_next;
        base_reg  <= base_next;
        e_reg     <= e_next;
        acc_reg   <= acc_next;
        sq_reg    <= sq_next;
        res_reg   <= res_next;
        prime_reg <= prime_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, prime_reg};

    // The multiplier is never started while it is still working
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_req.start |-> !mm_rsp.busy)
        else $error("multiply started while unit busy");

    // A finished multiply is only seen in a state that waits for it
    a_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_rsp.done |-> (state_reg == ST_EXPMUL || state_reg == ST_EXPSQ ||
                         state_reg == ST_SQR))
        else $error("multiply result arrived in a non-waiting state");

    // Even candidates other than two are always reported composite
    a_even_composite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !n_reg[0] && n_reg != W'(2)) |=> !m_tdata[0])
        else $error("even candidate reported prime");

    // Splitting n-1 always stops on a set bit, so d never reaches zero
    a_split_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPLIT) |-> (d_reg != '0))
        else $error("zero exponent while splitting n-1");

endmodule
